[hdl/ctf_pkg.sv]
// ============================================================================
// ctf_pkg
// Shared types and constants for the cassette tone framer.
// ============================================================================
`default_nettype none

package ctf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FAST_MODE = 3'd0;
    localparam logic [2:0] CFG_ZERO_FREQ = 3'd1;
    localparam logic [2:0] CFG_ONE_FREQ  = 3'd2;
    localparam logic [2:0] CFG_DIBIT_0   = 3'd3;
    localparam logic [2:0] CFG_DIBIT_1   = 3'd4;
    localparam logic [2:0] CFG_DIBIT_2   = 3'd5;
    localparam logic [2:0] CFG_DIBIT_3   = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int FREQ_W      = 14;
    localparam int CYCLES_W    = 12;

    // Default depth of the command queue between front and back.
    localparam int CTF_QUEUE_DEPTH = 2;

    // Reset values of the configuration registers.
    localparam logic [FREQ_W-1:0] RST_ZERO_FREQ = 14'd2000;
    localparam logic [FREQ_W-1:0] RST_ONE_FREQ  = 14'd1000;

    // Standard-mode framing tones.
    localparam logic [FREQ_W-1:0]   STD_LEAD_FREQ   = 14'd770;
    localparam logic [CYCLES_W-1:0] STD_LEAD_CYCLES = 12'd3500;
    localparam logic [FREQ_W-1:0]   STD_SYNC_FREQ   = 14'd2222;
    localparam logic [CYCLES_W-1:0] STD_SYNC_CYCLES = 12'd1;
    localparam logic [FREQ_W-1:0]   STD_CLOSE_FREQ  = 14'd100;
    localparam logic [7:0]          STD_SEED        = 8'hFF;

    // Fast-mode framing tones.
    localparam logic [FREQ_W-1:0]   FAST_LEAD_FREQ   = 14'd5000;
    localparam logic [CYCLES_W-1:0] FAST_LEAD_CYCLES = 12'd500;
    localparam logic [FREQ_W-1:0]   FAST_SYNC_FREQ   = 14'd10000;
    localparam logic [CYCLES_W-1:0] FAST_SYNC_CYCLES = 12'd2;
    localparam logic [FREQ_W-1:0]   FAST_CLOSE_FREQ  = 14'd3500;
    localparam logic [7:0]          FAST_SEED        = 8'h00;

    localparam logic [CYCLES_W-1:0] BIT_CYCLES   = 12'd1;
    localparam logic [CYCLES_W-1:0] CLOSE_CYCLES = 12'd2;

    // Live configuration as seen by the back end.
    typedef struct packed {
        logic                   fast_mode;
        logic [FREQ_W-1:0]      zero_bit_freq;
        logic [FREQ_W-1:0]      one_bit_freq;
        logic [3:0][FREQ_W-1:0] dibit_freq;
    } cfg_t;

    // One classified byte request, handed from front to back.
    typedef struct packed {
        logic       fast;       // mode of this byte
        logic       lead;       // byte opens a frame
        logic       fin;        // byte closes a frame
        logic [7:0] data;
        logic [7:0] check;      // frame checksum, valid when fin is set
    } cmd_t;

endpackage : ctf_pkg

`default_nettype wire

[hdl/ctf_front.sv]
// ============================================================================
// ctf_front
// Accepts byte requests, tracks the open frame and its checksum, and
// classifies each byte into a command for the back end.
// ============================================================================
`default_nettype none

module ctf_front import ctf_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fast_mode,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_final_byte,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd,
    output logic            in_frame
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] check_reg, check_next;
    logic [7:0] check_base;
    logic [7:0] check_sum;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // The seed follows the mode at the byte that opens the frame.
    assign check_base = in_frame_reg ? check_reg : (fast_mode ? FAST_SEED : STD_SEED);
    assign check_sum  = check_base ^ s_data_byte;

    always_comb begin
        q_cmd.fast  = fast_mode;
        q_cmd.lead  = !in_frame_reg;
        q_cmd.fin   = s_final_byte;
        q_cmd.data  = s_data_byte;
        q_cmd.check = check_sum;
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        check_next    = check_reg;
        if (q_push) begin
            if (s_final_byte) begin
                in_frame_next = 1'b0;
                check_next    = 8'h00;
            end else begin
                in_frame_next = 1'b1;
                check_next    = check_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            check_reg    <= 8'h00;
        end else begin
            in_frame_reg <= in_frame_next;
            check_reg    <= check_next;
        end
    end

    assign in_frame = in_frame_reg;

endmodule : ctf_front

`default_nettype wire

[hdl/ctf_queue.sv]
// ============================================================================
// ctf_queue
// Short first-in first-out queue of byte commands between front and back.
// ============================================================================
`default_nettype none

module ctf_queue import ctf_pkg::*; #(
    parameter int DEPTH = CTF_QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule : ctf_queue

`default_nettype wire

[hdl/ctf_back.sv]
// ============================================================================
// ctf_back
// Tone sequencer: expands one byte command into tone descriptors, one per
// cycle while m_ready allows, into a registered output stage.
// ============================================================================
`default_nettype none

module ctf_back import ctf_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_t                cfg,
    input  wire logic                q_not_empty,
    input  wire cmd_t                q_head,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [FREQ_W-1:0]        m_tone_freq,
    output logic [CYCLES_W-1:0]      m_tone_cycles,
    output logic                     m_short_high,
    output logic                     m_last_tone
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SYNC,
        PH_DATA,
        PH_CHECK,
        PH_CLOSE
    } phase_t;

    logic         busy_reg, busy_next;
    phase_t       phase_reg, phase_next;
    logic [2:0]   cnt_reg, cnt_next;
    cmd_t         cmd_reg, cmd_next;
    logic         valid_reg, valid_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [CYCLES_W-1:0] cycles_reg, cycles_next;
    logic         short_reg, short_next;
    logic         last_reg, last_next;

    logic                advance;
    logic [FREQ_W-1:0]   t_freq;
    logic [CYCLES_W-1:0] t_cycles;
    logic                t_short;
    logic                t_last;
    logic                byte_end;
    logic [2:0]          shamt;
    logic [7:0]          byte_sel;
    logic [7:0]          shifted;
    logic [FREQ_W-1:0]   bit_freq;

    assign advance = !valid_reg || m_ready;

    // Bit or bit-pair extraction, MSB first.
    assign shamt    = cmd_reg.fast ? {cnt_reg[1:0], 1'b0} : cnt_reg;
    assign byte_sel = (phase_reg == PH_CHECK) ? cmd_reg.check : cmd_reg.data;
    assign shifted  = byte_sel << shamt;
    assign bit_freq = cmd_reg.fast ? cfg.dibit_freq[shifted[7:6]]
                                   : (shifted[7] ? cfg.one_bit_freq : cfg.zero_bit_freq);
    assign byte_end = cmd_reg.fast ? (cnt_reg == 3'd3) : (cnt_reg == 3'd7);

    always_comb begin
        t_freq   = bit_freq;
        t_cycles = BIT_CYCLES;
        t_short  = 1'b0;
        t_last   = 1'b0;
        unique case (phase_reg)
            PH_LEAD: begin
                t_freq   = cmd_reg.fast ? FAST_LEAD_FREQ : STD_LEAD_FREQ;
                t_cycles = cmd_reg.fast ? FAST_LEAD_CYCLES : STD_LEAD_CYCLES;
            end
            PH_SYNC: begin
                t_freq   = cmd_reg.fast ? FAST_SYNC_FREQ : STD_SYNC_FREQ;
                t_cycles = cmd_reg.fast ? FAST_SYNC_CYCLES : STD_SYNC_CYCLES;
                t_short  = !cmd_reg.fast;
            end
            PH_DATA: begin
                t_last = byte_end && !cmd_reg.fin;
            end
            PH_CHECK: begin
            end
            PH_CLOSE: begin
                t_freq   = cmd_reg.fast ? FAST_CLOSE_FREQ : STD_CLOSE_FREQ;
                t_cycles = CLOSE_CYCLES;
                t_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // A new command is loaded as the previous one hands out its last tone.
    assign q_pop = q_not_empty && (!busy_reg || (advance && t_last));

    always_comb begin
        busy_next   = busy_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        valid_next  = valid_reg;
        freq_next   = freq_reg;
        cycles_next = cycles_reg;
        short_next  = short_reg;
        last_next   = last_reg;

        if (advance) begin
            valid_next  = busy_reg;
            freq_next   = t_freq;
            cycles_next = t_cycles;
            short_next  = t_short;
            last_next   = t_last;
        end

        if (q_pop) begin
            busy_next  = 1'b1;
            cmd_next   = q_head;
            phase_next = q_head.lead ? PH_LEAD : PH_DATA;
            cnt_next   = 3'd0;
        end else if (busy_reg && advance) begin
            if (t_last) begin
                busy_next = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_LEAD:  phase_next = PH_SYNC;
                    PH_SYNC: begin
                        phase_next = PH_DATA;
                        cnt_next   = 3'd0;
                    end
                    PH_DATA, PH_CHECK: begin
                        if (byte_end) begin
                            phase_next = (phase_reg == PH_DATA) ? PH_CHECK : PH_CLOSE;
                            cnt_next   = 3'd0;
                        end else begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_LEAD;
            cnt_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
        cmd_reg    <= cmd_next;
        freq_reg   <= freq_next;
        cycles_reg <= cycles_next;
        short_reg  <= short_next;
        last_reg   <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_tone_freq   = freq_reg;
    assign m_tone_cycles = cycles_reg;
    assign m_short_high  = short_reg;
    assign m_last_tone   = last_reg;

endmodule : ctf_back

`default_nettype wire

[hdl/cassette_tone_framer_core.sv]
// ============================================================================
// cassette_tone_framer_core
// Turns framed payload bytes into cassette tone descriptors.
// ============================================================================
// A byte's first tone goes through the queue, cmd_reg and the output register.
// Throughput: the tone sequencer hands out one descriptor per cycle unless
//   m_ready stalls it; a byte gives 8 descriptors (standard) or 4 (fast), plus
//   2 on opening a frame and 9 (standard) or 5 (fast) on closing; up to 19.
// Reset (aresetn low, synchronous) closes any frame, empties the queue and
//   resets config and control registers; no clearing pass is needed.
`default_nettype none

module cassette_tone_framer_core import ctf_pkg::*; #(
    parameter int QUEUE_DEPTH = CTF_QUEUE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [FREQ_W-1:0]      cfg_data,
    // Byte requests
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic                   s_final_byte,
    // Tone descriptors
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [FREQ_W-1:0]           m_tone_freq,
    output logic [CYCLES_W-1:0]         m_tone_cycles,
    output logic                        m_short_high,
    output logic                        m_last_tone
);

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the data bus is as
    // wide as the widest register and the mode bit uses its LSB. An index
    // past the last register is accepted and ignored.
    // ------------------------------------------------------------------------
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_mode     <= 1'b0;
            cfg_reg.zero_bit_freq <= RST_ZERO_FREQ;
            cfg_reg.one_bit_freq  <= RST_ONE_FREQ;
            cfg_reg.dibit_freq    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FAST_MODE: cfg_reg.fast_mode     <= cfg_data[0];
                CFG_ZERO_FREQ: cfg_reg.zero_bit_freq <= cfg_data;
                CFG_ONE_FREQ:  cfg_reg.one_bit_freq  <= cfg_data;
                CFG_DIBIT_0:   cfg_reg.dibit_freq[0] <= cfg_data;
                CFG_DIBIT_1:   cfg_reg.dibit_freq[1] <= cfg_data;
                CFG_DIBIT_2:   cfg_reg.dibit_freq[2] <= cfg_data;
                CFG_DIBIT_3:   cfg_reg.dibit_freq[3] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Front end: takes a request whenever the queue has room, works out
    // whether the byte opens or closes a frame and folds it into the running
    // checksum. The checksum of a closing byte rides along in its command.
    // ------------------------------------------------------------------------
    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_head;
    logic in_frame;

    ctf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fast_mode    (cfg_reg.fast_mode),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd),
        .in_frame     (in_frame)
    );

    // ------------------------------------------------------------------------
    // Command queue: lets the front keep taking bytes while the back end is
    // still spelling out an earlier one.
    // ------------------------------------------------------------------------
    ctf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head)
    );

    // ------------------------------------------------------------------------
    // Back end: walks lead-in, sync, data bits, checksum bits and the closing
    // tone as the command asks, one descriptor per cycle unless stalled, into
    // the output register, and loads the next command as the last tone leaves.
    // ------------------------------------------------------------------------
    ctf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tone_freq   (m_tone_freq),
        .m_tone_cycles (m_tone_cycles),
        .m_short_high  (m_short_high),
        .m_last_tone   (m_last_tone)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A closing byte leaves the frame closed; any other byte leaves it open.
    a_frame_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (in_frame == !$past(s_final_byte)))
        else $error("frame state does not follow the final_byte flag");

    // Only the standard sync tone uses the short duty cycle.
    a_short_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_short_high) |->
            (m_tone_freq == STD_SYNC_FREQ && m_tone_cycles == STD_SYNC_CYCLES))
        else $error("short duty on a tone other than the sync tone");

    // The back end never pops an empty queue; the front never overfills it.
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(q_pop && !q_not_empty)) && (!(q_push && q_full)))
        else $error("command queue overrun or underrun");

endmodule : cassette_tone_framer_core

`default_nettype wire

[dv/tb_cassette_tone_framer_core.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_cassette_tone_framer_core
// Self-checking bench for the cassette tone framer core.
// ----------------------------------------------------------------------------
// Byte requests go in on the s_ channel and tone descriptors come out on the
// m_ channel. A predictor in the bench tracks frame state, the running XOR
// and a copy of the register file, and expands every accepted request into
// the tones it should cause. Every descriptor that comes out is compared
// field by field with the oldest predicted one. A short directed table runs
// first, then randomized phases with new register settings, random frame
// lengths, sender bursts, receiver stalls and one long receiver hold-off.
// ============================================================================

module tb_cassette_tone_framer_core;
    import ctf_pkg::*;

    // Run length and pacing.
    localparam int TIMEOUT_NS       = 1_000_000;
    localparam int RAND_PHASES      = 10;
    localparam int PHASE_REQUESTS   = 36;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int HOLD_PHASE       = 2;
    localparam int TAIL_CYCLES      = 40;

    // Framing tones, written out independently of the package constants so
    // that a wrong constant in the design shows up as a mismatch.
    localparam logic [FREQ_W-1:0]   STD_LEAD_HZ   = 14'd770;
    localparam logic [CYCLES_W-1:0] STD_LEAD_N    = 12'd3500;
    localparam logic [FREQ_W-1:0]   STD_SYNC_HZ   = 14'd2222;
    localparam logic [FREQ_W-1:0]   STD_CLOSE_HZ  = 14'd100;
    localparam logic [FREQ_W-1:0]   FAST_LEAD_HZ  = 14'd5000;
    localparam logic [CYCLES_W-1:0] FAST_LEAD_N   = 12'd500;
    localparam logic [FREQ_W-1:0]   FAST_SYNC_HZ  = 14'd10000;
    localparam logic [FREQ_W-1:0]   FAST_CLOSE_HZ = 14'd3500;
    localparam logic [FREQ_W-1:0]   FREQ_MAX      = 14'h3FFF;

    // One tone descriptor as seen on the result channel.
    typedef struct packed {
        logic [FREQ_W-1:0]   freq;
        logic [CYCLES_W-1:0] cycles;
        logic                short_high;
        logic                last_tone;
    } tone_t;

    // One row of the directed table: either a register write or a byte
    // request. A byte row may carry a hand-typed first tone that replaces
    // the predicted one.
    typedef enum logic [0:0] {ROW_BYTE, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [FREQ_W-1:0]      reg_val;
        logic [7:0]             data;
        logic                   fin;
        logic                   typed;
        tone_t                  first_tone;
    } stim_row_t;

    // Clock, reset and DUT ports. Every input has a known value at time 0.
    logic                   aclk;
    logic                   aresetn      = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [FREQ_W-1:0]      cfg_data     = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte  = '0;
    logic                   s_final_byte = 1'b0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [FREQ_W-1:0]      m_tone_freq;
    logic [CYCLES_W-1:0]    m_tone_cycles;
    logic                   m_short_high;
    logic                   m_last_tone;

    // Hand-typed expectation that travels with the current request.
    logic                   s_typed      = 1'b0;
    tone_t                  s_typed_tone = '0;

    // Predictor state: register copy, frame flag and running checksum.
    cfg_t       shadow_cfg;
    bit         frame_open;
    logic [7:0] frame_xor;

    // Tones predicted for the request being handled, and all tones still
    // owed by the design, oldest first.
    tone_t      step_tones[$];
    tone_t      pending_tones[$];

    int         fail_count = 0;
    bit         long_hold_pending = 1'b0;

    cassette_tone_framer_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tone_freq   (m_tone_freq),
        .m_tone_cycles (m_tone_cycles),
        .m_short_high  (m_short_high),
        .m_last_tone   (m_last_tone)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void emit_tone(input logic [FREQ_W-1:0] freq,
                                      input logic [CYCLES_W-1:0] cycles,
                                      input logic short_high);
        tone_t t;
        t.freq       = freq;
        t.cycles     = cycles;
        t.short_high = short_high;
        t.last_tone  = 1'b0;
        step_tones.push_back(t);
    endfunction

    // A byte goes out MSB first: one single-cycle tone per bit in standard
    // mode, or one per bit pair in fast mode. The mode in force right now
    // decides, even in the middle of a frame.
    function automatic void emit_byte(input logic [7:0] v);
        logic [1:0] pair;
        if (shadow_cfg.fast_mode) begin
            for (int k = 0; k < 4; k++) begin
                pair = v[(7 - 2 * k) -: 2];
                emit_tone(shadow_cfg.dibit_freq[pair], 12'd1, 1'b0);
            end
        end else begin
            for (int k = 0; k < 8; k++) begin
                emit_tone(v[7 - k] ? shadow_cfg.one_bit_freq : shadow_cfg.zero_bit_freq,
                          12'd1, 1'b0);
            end
        end
    endfunction

    // Works out every tone that one byte request causes. The checksum seed
    // is picked by the mode at frame start; the byte, the checksum byte and
    // the closing tone each use the mode in force when they are sent.
    function automatic void predict_tones_for_byte(input logic [7:0] data_byte,
                                                   input logic final_byte);
        step_tones.delete();
        if (!frame_open) begin
            if (shadow_cfg.fast_mode) begin
                emit_tone(FAST_LEAD_HZ, FAST_LEAD_N, 1'b0);
                emit_tone(FAST_SYNC_HZ, 12'd2, 1'b0);
                frame_xor = 8'h00;
            end else begin
                emit_tone(STD_LEAD_HZ, STD_LEAD_N, 1'b0);
                // The standard sync cycle is the only short-duty tone.
                emit_tone(STD_SYNC_HZ, 12'd1, 1'b1);
                frame_xor = 8'hFF;
            end
            frame_open = 1'b1;
        end
        emit_byte(data_byte);
        frame_xor = frame_xor ^ data_byte;
        if (final_byte) begin
            emit_byte(frame_xor);
            emit_tone(shadow_cfg.fast_mode ? FAST_CLOSE_HZ : STD_CLOSE_HZ, 12'd2, 1'b0);
            frame_open = 1'b0;
            frame_xor  = 8'h00;
        end
    endfunction

    function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [FREQ_W-1:0] val);
        case (idx)
            CFG_FAST_MODE: shadow_cfg.fast_mode        = val[0];
            CFG_ZERO_FREQ: shadow_cfg.zero_bit_freq    = val;
            CFG_ONE_FREQ:  shadow_cfg.one_bit_freq     = val;
            CFG_DIBIT_0:   shadow_cfg.dibit_freq[0]    = val;
            CFG_DIBIT_1:   shadow_cfg.dibit_freq[1]    = val;
            CFG_DIBIT_2:   shadow_cfg.dibit_freq[2]    = val;
            CFG_DIBIT_3:   shadow_cfg.dibit_freq[3]    = val;
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. All three channels are sampled at the rising edge, before any
    // of this edge's nonblocking updates land, so the handshakes seen here
    // are exactly the ones the design saw.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : tone_monitor
        tone_t t;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_reg_write(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                predict_tones_for_byte(s_data_byte, s_final_byte);
                foreach (step_tones[i]) begin
                    t = step_tones[i];
                    if (i == 0 && s_typed) begin
                        t = s_typed_tone;
                    end
                    // Only the last tone of a request carries the flag.
                    t.last_tone = (i == step_tones.size() - 1);
                    pending_tones.push_back(t);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_tones.size() == 0) begin
                    $error("unexpected tone: freq %0d, cycles %0d", m_tone_freq,
                           m_tone_cycles);
                    fail_count++;
                end else begin
                    t = pending_tones.pop_front();
                    check_field("tone_freq", 32'(t.freq), 32'(m_tone_freq));
                    check_field("tone_cycles", 32'(t.cycles), 32'(m_tone_cycles));
                    check_field("short_high", 32'(t.short_high), 32'(m_short_high));
                    check_field("last_tone", 32'(t.last_tone), 32'(m_last_tone));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It runs through a few stall patterns of its own, each for a
    // random stretch, and on request holds ready low for a long time so the
    // internal queue fills and the design has to push back on its input.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int pattern;
        int left;
        int tick;
        forever begin
            @(posedge aclk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    pattern = $urandom_range(0, 3);
                    left    = $urandom_range(40, 200);
                end
                left--;
                tick++;
                case (pattern)
                    0: m_ready <= 1'b1;                           // never stalls
                    1: m_ready <= ($urandom_range(0, 1) == 1);    // coin toss
                    2: m_ready <= (tick % 5 == 0);                // one in five
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // Waits until every predicted tone has come out. The first edge always
    // passes, so the prediction for a request accepted at the current edge
    // has been queued before the count is looked at.
    task automatic wait_for_tones();
        do @(posedge aclk); while (pending_tones.size() != 0);
    endtask

    // Drops both request channels and lets the design drain completely.
    task automatic quiesce();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        wait_for_tones();
    endtask

    // Valid is left high on return; the caller lowers it when it idles.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [FREQ_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Offers one byte request and returns at the edge where it is taken.
    task automatic send_byte(input logic [7:0] data_byte, input logic final_byte,
                             input logic typed, input tone_t typed_tone);
        s_valid      <= 1'b1;
        s_data_byte  <= data_byte;
        s_final_byte <= final_byte;
        s_typed      <= typed;
        s_typed_tone <= typed_tone;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FREQ_MAX;
            default: return FREQ_W'($urandom_range(0, 16383));
        endcase
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [FREQ_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] data_byte,
                                           input logic final_byte);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_BYTE;
        r.data = data_byte;
        r.fin  = final_byte;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] data_byte,
                                            input logic final_byte,
                                            input logic [FREQ_W-1:0] freq,
                                            input logic [CYCLES_W-1:0] cycles,
                                            input logic short_high);
        stim_row_t r;
        r                       = byte_row(data_byte, final_byte);
        r.typed                 = 1'b1;
        r.first_tone.freq       = freq;
        r.first_tone.cycles     = cycles;
        r.first_tone.short_high = short_high;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t rows[$];
        int        frame_left;
        int        burst_left;
        bit        steady;
        logic      fin;

        // Predictor starts from the reset state of the design.
        shadow_cfg               = '0;
        shadow_cfg.zero_bit_freq = 14'd2000;
        shadow_cfg.one_bit_freq  = 14'd1000;
        frame_open               = 1'b0;
        frame_xor                = 8'h00;

        // Directed table. Rows with a typed first tone are checked against
        // that value; all other tones come from the predictor.
        // Out of reset: standard lead-in, then a frame whose checksum is 0.
        rows.push_back(typed_row(8'h00, 1'b0, 14'd770, 12'd3500, 1'b0));
        rows.push_back(byte_row(8'hFF, 1'b1));
        // A byte that opens and closes a frame gives the longest burst.
        rows.push_back(typed_row(8'hA5, 1'b1, 14'd770, 12'd3500, 1'b0));
        // Bit frequencies at their extremes.
        rows.push_back(reg_row(CFG_ZERO_FREQ, FREQ_MAX));
        rows.push_back(reg_row(CFG_ONE_FREQ, 14'd0));
        rows.push_back(typed_row(8'h5A, 1'b0, 14'd770, 12'd3500, 1'b0));
        rows.push_back(typed_row(8'h00, 1'b0, FREQ_MAX, 12'd1, 1'b0));
        // Switch to fast mode with a standard frame still open.
        rows.push_back(reg_row(CFG_FAST_MODE, 14'd1));
        rows.push_back(reg_row(CFG_DIBIT_0, 14'd0));
        rows.push_back(reg_row(CFG_DIBIT_1, 14'd8191));
        rows.push_back(reg_row(CFG_DIBIT_2, 14'd1));
        rows.push_back(reg_row(CFG_DIBIT_3, FREQ_MAX));
        // Every bit pair once, then the fast close.
        rows.push_back(byte_row(8'h1B, 1'b1));
        rows.push_back(typed_row(8'hE4, 1'b1, 14'd5000, 12'd500, 1'b0));
        rows.push_back(byte_row(8'h00, 1'b0));
        rows.push_back(byte_row(8'hFF, 1'b0));
        rows.push_back(typed_row(8'hC0, 1'b0, FREQ_MAX, 12'd1, 1'b0));
        // Back to standard mode inside a frame that was seeded in fast mode.
        rows.push_back(reg_row(CFG_FAST_MODE, 14'd0));
        rows.push_back(byte_row(8'hAA, 1'b1));
        rows.push_back(reg_row(CFG_ZERO_FREQ, 14'd0));
        rows.push_back(reg_row(CFG_ONE_FREQ, FREQ_MAX));
        rows.push_back(typed_row(8'h80, 1'b0, 14'd770, 12'd3500, 1'b0));
        rows.push_back(typed_row(8'h80, 1'b1, FREQ_MAX, 12'd1, 1'b0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register rows wait for the design to go idle; byte rows go back to
        // back so that the frame logic sees requests with no gaps.
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG) begin
                quiesce();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                if (cfg_valid) begin
                    cfg_valid <= 1'b0;
                end
                send_byte(rows[i].data, rows[i].fin, rows[i].typed, rows[i].first_tone);
            end
        end

        // Random phases. Each one starts from an idle design with new
        // register values; frames run across phase boundaries on purpose,
        // so mode changes inside an open frame keep coming up.
        frame_left = 0;
        burst_left = 0;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            quiesce();
            write_reg(CFG_FAST_MODE, (phase < 2) ? FREQ_W'(phase) :
                                                   FREQ_W'($urandom_range(0, 1)));
            for (int idx = CFG_ZERO_FREQ; idx <= CFG_DIBIT_3; idx++) begin
                if (phase == 0 || $urandom_range(0, 1) == 1) begin
                    write_reg(CFG_INDEX_W'(idx), pick_freq());
                end
            end
            cfg_valid <= 1'b0;

            // In the hold phase the sender keeps pushing while the receiver
            // sits still, so the design fills up and stalls its input.
            steady = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE) begin
                long_hold_pending = 1'b1;
            end

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Now and then the sender waits for every tone to come out.
                if ((phase == 1 && n == PHASE_REQUESTS / 2) ||
                    $urandom_range(0, 40) == 0) begin
                    idle_sender(0);
                    wait_for_tones();
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    if (!steady) begin
                        idle_sender($urandom_range(1, 6));
                    end
                end
                burst_left--;

                // Mostly short frames, sometimes a long one.
                if (frame_left == 0) begin
                    frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) :
                                                               $urandom_range(1, 5);
                end
                fin = (frame_left == 1);
                frame_left--;
                send_byte(8'($urandom), fin, 1'b0, '0);
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_tones.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop in case the design hangs or drops tones.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
